[sv/ble_pkg.sv]
// shared types, op codes and defaults for the bounded list engine
`timescale 1ns / 1ps

package ble_pkg;

  // default storage geometry
  localparam int unsigned DEPTH_DEF     = 64;
  localparam int unsigned ELEM_BITS_DEF = 32;

  // request op codes
  typedef enum logic [2:0] {
    OP_PUSH      = 3'd0,
    OP_POP       = 3'd1,
    OP_SET       = 3'd2,
    OP_GET       = 3'd3,
    OP_REMOVE    = 3'd4,
    OP_CLEAR     = 3'd5,
    OP_SEARCH    = 3'd6,
    OP_ZERO      = 3'd7
  } op_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CAPT,
    ST_MOVE,
    ST_SCAN,
    ST_ZERO,
    ST_DONE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load_req;
    logic set_ok;
    logic push;
    logic set_wr;
    logic rd_idx;
    logic rd_front;
    logic cap_data;
    logic move_init;
    logic move_step;
    logic move_fin;
    logic clear_all;
    logic zero_init;
    logic zero_step;
    logic scan_init;
    logic scan_step;
    logic out_load;
  } ble_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_e  op;
    logic push_ok;
    logic idx_ok;
    logic remove_ok;
    logic nonempty;
    logic move_done;
    logic zero_done;
    logic scan_done;
    logic out_free;
  } ble_sts_t;

endpackage

[sv/ble_ram.sv]
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module ble_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_data_q <= mem_q[raddr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[sv/ble_datapath.sv]
// datapath: request registers, fill count, walk pointers, word store and result register
`timescale 1ns / 1ps

module ble_datapath #(
  parameter int unsigned DEPTH     = ble_pkg::DEPTH_DEF,
  parameter int unsigned ELEM_BITS = ble_pkg::ELEM_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_wdata_i,
  input  logic [2:0]        op_i,
  input  logic [5:0]        index_i,
  input  logic [6:0]        count_i,
  input  logic [31:0]       value_i,
  input  ble_pkg::ble_cmd_t cmd_i,
  output ble_pkg::ble_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              ok_o,
  output logic [31:0]       data_o,
  output logic [5:0]        where_o,
  output logic [6:0]        live_count_o
);

  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W  = (FILL_W > 8) ? FILL_W : 8;
  localparam int unsigned WIDE_W = (ELEM_BITS > 32) ? ELEM_BITS : 32;

  // configuration and request registers
  logic [6:0]           max_q;
  ble_pkg::op_e         op_q;
  logic [5:0]           idx_q;
  logic [6:0]           cnt_q;
  logic [ELEM_BITS-1:0] key_q;
  logic [WIDE_W-1:0]    val_wide;

  // list state and walk pointers
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [CMP_W-1:0]     ptr_q, ptr_d;
  logic [ADDR_W-1:0]    dst_q, dst_d;
  logic                 pend_q, pend_d;
  logic [ADDR_W-1:0]    pend_addr_q, pend_addr_d;
  logic [6:0]           n_q, n_d;
  logic [CMP_W-1:0]     start_x;

  // result and output registers
  logic                 res_ok_q, res_ok_d;
  logic [31:0]          res_data_q, res_data_d;
  logic [5:0]           res_where_q, res_where_d;
  logic                 out_valid_q;
  logic                 out_ok_q;
  logic [31:0]          out_data_q;
  logic [5:0]           out_where_q;
  logic [6:0]           out_live_q;

  // ram ports
  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [ELEM_BITS-1:0] ram_wdata, ram_rdata;
  logic [WIDE_W-1:0]    rd_wide;

  // widened views for compares
  logic [CMP_W-1:0]     fill_x, idx_x, cnt_x, max_x, end_x, depth_x, pend_x;
  logic                 rd_more, scan_hit;

  assign val_wide = WIDE_W'(value_i);
  assign rd_wide  = WIDE_W'(ram_rdata);
  assign fill_x   = CMP_W'(fill_q);
  assign idx_x    = CMP_W'(idx_q);
  assign cnt_x    = CMP_W'(cnt_q);
  assign max_x    = CMP_W'(max_q);
  assign end_x    = idx_x + cnt_x;
  assign depth_x  = CMP_W'(DEPTH);
  assign pend_x   = CMP_W'(pend_addr_q);
  assign rd_more  = ptr_q < fill_x;
  assign scan_hit = pend_q && (ram_rdata == key_q);

  // status to controller
  always_comb begin
    sts_o.op        = op_q;
    sts_o.push_ok   = (fill_x < depth_x) && !((max_q != '0) && (fill_x >= max_x));
    sts_o.idx_ok    = idx_x < fill_x;
    sts_o.remove_ok = (cnt_q != '0) && (end_x <= fill_x);
    sts_o.nonempty  = fill_q != '0;
    sts_o.move_done = !pend_q && !rd_more;
    sts_o.zero_done = !rd_more;
    sts_o.scan_done = scan_hit || (!pend_q && !rd_more);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // store access steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (cmd_i.push) begin
      ram_we    = 1'b1;
      ram_waddr = fill_x[ADDR_W-1:0];
      ram_wdata = key_q;
    end
    if (cmd_i.set_wr) begin
      ram_we    = 1'b1;
      ram_waddr = idx_x[ADDR_W-1:0];
      ram_wdata = key_q;
    end
    if (cmd_i.zero_step) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_q[ADDR_W-1:0];
    end
    if (cmd_i.move_step && pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_q;
      ram_wdata = ram_rdata;
    end
    if ((cmd_i.move_step || cmd_i.scan_step) && rd_more) begin
      ram_re    = 1'b1;
      ram_raddr = ptr_q[ADDR_W-1:0];
    end
    if (cmd_i.rd_idx) begin
      ram_re    = 1'b1;
      ram_raddr = idx_x[ADDR_W-1:0];
    end
    if (cmd_i.rd_front) begin
      ram_re    = 1'b1;
      ram_raddr = '0;
    end
  end

  // walk pointer and fill updates
  always_comb begin
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    dst_d       = dst_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    n_d         = n_q;
    start_x     = (op_q == ble_pkg::OP_POP) ? '0 : idx_x;
    if (cmd_i.push) begin
      fill_d = fill_q + FILL_W'(1);
    end
    if (cmd_i.clear_all) begin
      fill_d = '0;
    end
    if (cmd_i.move_fin) begin
      fill_d = fill_q - FILL_W'(n_q);
    end
    if (cmd_i.move_init) begin
      n_d    = (op_q == ble_pkg::OP_POP) ? 7'd1 : cnt_q;
      ptr_d  = start_x + CMP_W'(n_d);
      dst_d  = start_x[ADDR_W-1:0];
      pend_d = 1'b0;
    end
    if (cmd_i.move_step) begin
      pend_d      = rd_more;
      pend_addr_d = dst_q;
      if (rd_more) begin
        ptr_d = ptr_q + CMP_W'(1);
        dst_d = dst_q + ADDR_W'(1);
      end
    end
    if (cmd_i.scan_init) begin
      ptr_d  = idx_x;
      pend_d = 1'b0;
    end
    if (cmd_i.scan_step) begin
      pend_d      = rd_more;
      pend_addr_d = ptr_q[ADDR_W-1:0];
      if (rd_more) begin
        ptr_d = ptr_q + CMP_W'(1);
      end
    end
    if (cmd_i.zero_init) begin
      ptr_d = '0;
    end
    if (cmd_i.zero_step) begin
      ptr_d = ptr_q + CMP_W'(1);
    end
  end

  // result fields
  always_comb begin
    res_ok_d    = res_ok_q;
    res_data_d  = res_data_q;
    res_where_d = res_where_q;
    if (cmd_i.load_req) begin
      res_ok_d    = 1'b0;
      res_data_d  = '0;
      res_where_d = '0;
    end
    if (cmd_i.set_ok) begin
      res_ok_d = 1'b1;
    end
    if (cmd_i.push) begin
      res_where_d = fill_x[5:0];
    end
    if (cmd_i.cap_data) begin
      res_data_d = rd_wide[31:0];
    end
    if (cmd_i.scan_step && scan_hit) begin
      res_ok_d    = 1'b1;
      res_where_d = pend_x[5:0];
    end
  end

  // control state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= '0;
      fill_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      fill_q <= fill_d;
      pend_q <= pend_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q  <= ble_pkg::op_e'(op_i);
      idx_q <= index_i;
      cnt_q <= count_i;
      key_q <= val_wide[ELEM_BITS-1:0];
    end
    ptr_q       <= ptr_d;
    dst_q       <= dst_d;
    pend_addr_q <= pend_addr_d;
    n_q         <= n_d;
    res_ok_q    <= res_ok_d;
    res_data_q  <= res_data_d;
    res_where_q <= res_where_d;
    if (cmd_i.out_load) begin
      out_ok_q    <= res_ok_q;
      out_data_q  <= res_data_q;
      out_where_q <= res_where_q;
      out_live_q  <= fill_x[6:0];
    end
  end

  ble_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (ram_re),
    .raddr_i   (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign ok_o         = out_ok_q;
  assign data_o       = out_data_q;
  assign where_o      = out_where_q;
  assign live_count_o = out_live_q;

  // an append grows the list by exactly one
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> fill_q == ($past(fill_q) + FILL_W'(1)))
    else $error("append did not grow fill by one");

  // during compaction the write always trails the read
  a_move_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.move_step && pend_q && rd_more) |-> (pend_x < ptr_q))
    else $error("compaction write overtook its read");

  // the list never holds more words than the store
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_x <= depth_x)
    else $error("fill exceeds store depth");

endmodule

[sv/ble_ctrl.sv]
// controller: sequences each request through the datapath
`timescale 1ns / 1ps

module ble_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ble_pkg::ble_sts_t sts_i,
  output ble_pkg::ble_cmd_t cmd_o
);

  ble_pkg::state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ble_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ble_pkg::ST_EXEC;
        end
      end
      ble_pkg::ST_EXEC: begin
        unique case (sts_i.op)
          ble_pkg::OP_POP: begin
            state_d = sts_i.nonempty ? ble_pkg::ST_CAPT : ble_pkg::ST_DONE;
          end
          ble_pkg::OP_GET: begin
            state_d = sts_i.idx_ok ? ble_pkg::ST_CAPT : ble_pkg::ST_DONE;
          end
          ble_pkg::OP_REMOVE: begin
            state_d = sts_i.remove_ok ? ble_pkg::ST_MOVE : ble_pkg::ST_DONE;
          end
          ble_pkg::OP_SEARCH: begin
            state_d = ble_pkg::ST_SCAN;
          end
          ble_pkg::OP_ZERO: begin
            state_d = sts_i.nonempty ? ble_pkg::ST_ZERO : ble_pkg::ST_DONE;
          end
          default: begin
            state_d = ble_pkg::ST_DONE;
          end
        endcase
      end
      ble_pkg::ST_CAPT: begin
        state_d = (sts_i.op == ble_pkg::OP_POP) ? ble_pkg::ST_MOVE : ble_pkg::ST_DONE;
      end
      ble_pkg::ST_MOVE: begin
        if (sts_i.move_done) begin
          state_d = ble_pkg::ST_DONE;
        end
      end
      ble_pkg::ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = ble_pkg::ST_DONE;
        end
      end
      ble_pkg::ST_ZERO: begin
        if (sts_i.zero_done) begin
          state_d = ble_pkg::ST_DONE;
        end
      end
      ble_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ble_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ble_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ble_pkg::ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
      end
      ble_pkg::ST_EXEC: begin
        unique case (sts_i.op)
          ble_pkg::OP_PUSH: begin
            cmd_o.push   = sts_i.push_ok;
            cmd_o.set_ok = sts_i.push_ok;
          end
          ble_pkg::OP_POP: begin
            cmd_o.rd_front  = sts_i.nonempty;
            cmd_o.move_init = sts_i.nonempty;
            cmd_o.set_ok    = sts_i.nonempty;
          end
          ble_pkg::OP_SET: begin
            cmd_o.set_wr = sts_i.idx_ok;
            cmd_o.set_ok = sts_i.idx_ok;
          end
          ble_pkg::OP_GET: begin
            cmd_o.rd_idx = sts_i.idx_ok;
            cmd_o.set_ok = sts_i.idx_ok;
          end
          ble_pkg::OP_REMOVE: begin
            cmd_o.move_init = sts_i.remove_ok;
            cmd_o.set_ok    = sts_i.remove_ok;
          end
          ble_pkg::OP_CLEAR: begin
            cmd_o.clear_all = sts_i.nonempty;
            cmd_o.set_ok    = sts_i.nonempty;
          end
          ble_pkg::OP_SEARCH: begin
            cmd_o.scan_init = 1'b1;
          end
          ble_pkg::OP_ZERO: begin
            cmd_o.zero_init = sts_i.nonempty;
            cmd_o.set_ok    = sts_i.nonempty;
          end
          default: begin
            cmd_o.set_ok = 1'b0;
          end
        endcase
      end
      ble_pkg::ST_CAPT: begin
        cmd_o.cap_data = 1'b1;
      end
      ble_pkg::ST_MOVE: begin
        cmd_o.move_step = 1'b1;
        cmd_o.move_fin  = sts_i.move_done;
      end
      ble_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      ble_pkg::ST_ZERO: begin
        cmd_o.zero_step = !sts_i.zero_done;
      end
      ble_pkg::ST_DONE: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
        cmd_o.load_req = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ble_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded over a pending one");

  // an accepted request always starts execution next cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ble_pkg::ST_IDLE && in_valid_i) |=> (state_q == ble_pkg::ST_EXEC))
    else $error("accepted request did not enter execution");

  // a finished compaction goes straight to the result
  a_move_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ble_pkg::ST_MOVE && sts_i.move_done) |=> (state_q == ble_pkg::ST_DONE))
    else $error("compaction did not finish");

endmodule

[sv/bounded_list_engine.sv]
// top level of the bounded list engine
`timescale 1ns / 1ps

// Packed list of ELEM_BITS-wide words in a DEPTH-entry store, one request at a time and
// one result per request. Pop moves the words above the front word down by one and
// remove_range moves the words above the removed range down, zero_all clears every live
// word, and search examines the words from the start index up to the first match or the
// end of the list. These walks use the store's single read port and single write port,
// which move, compare or clear one word per cycle. A new request is taken while the
// previous result still waits in the output register. The store needs no clearing pass
// after reset: only live words, which were all written, are ever read. max_count is
// written through cfg_we_i and should only change while no request is in flight.

module bounded_list_engine #(
  parameter int unsigned DEPTH     = ble_pkg::DEPTH_DEF,
  parameter int unsigned ELEM_BITS = ble_pkg::ELEM_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [5:0]  index_i,
  input  logic [6:0]  count_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [31:0] data_o,
  output logic [5:0]  where_o,
  output logic [6:0]  live_count_o
);

  ble_pkg::ble_cmd_t cmd;
  ble_pkg::ble_sts_t sts;

  // request sequencer
  ble_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage and result path
  ble_datapath #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (ELEM_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .op_i         (op_i),
    .index_i      (index_i),
    .count_i      (count_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ok_o         (ok_o),
    .data_o       (data_o),
    .where_o      (where_o),
    .live_count_o (live_count_o)
  );

endmodule
